// ===== hdl/drbs_pkg.sv =====
`default_nettype none

package drbs_pkg;

    localparam int RANGE_W     = 16;
    localparam int DATA_W      = 14;
    localparam int CALIB_SUM_W = 20;
    localparam int COUNT_W     = 7;
    localparam int REL_W       = 15;
    localparam int QUOT_W      = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam int LIMIT_MM  = 8200;
    localparam int NO_TARGET = 65535;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_B    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_COUNT = 2'd2;

    localparam logic [COUNT_W-1:0] CALIB_COUNT_RESET = 7'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL_CHECK,
        ST_CAL_DIV,
        ST_PUSH,
        ST_WIN,
        ST_AVG,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/drbs_div.sv =====
`default_nettype none

module drbs_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [drbs_pkg::CALIB_SUM_W-1:0]    dividend,
    input  logic [drbs_pkg::COUNT_W-1:0]        divisor,
    output logic                                done,
    output logic [drbs_pkg::QUOT_W-1:0]         quotient
);
    import drbs_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W + 1);

    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0]  shift_reg, shift_next;
    logic [COUNT_W-1:0] divisor_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   trial;
    logic               ge;

    // The quotient is known to fit in QUOT_W bits, so the upper dividend bits
    // start out as the partial remainder and only QUOT_W steps are needed.
    always_comb begin
        trial      = {rem_reg, shift_reg[QUOT_W-1]};
        ge         = trial >= {1'b0, divisor_reg};
        rem_next   = ge ? COUNT_W'(trial - {1'b0, divisor_reg}) : trial[COUNT_W-1:0];
        shift_next = {shift_reg[QUOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(QUOT_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg     <= COUNT_W'(dividend[CALIB_SUM_W-1:QUOT_W]);
            shift_reg   <= dividend[QUOT_W-1:0];
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

`default_nettype wire

// ===== hdl/drbs_win.sv =====
`default_nettype none

module drbs_win #(
    parameter int WINDOW = 5
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            push,
    input  logic [drbs_pkg::DATA_W-1:0]                     new_a,
    input  logic [drbs_pkg::DATA_W-1:0]                     new_b,
    output logic                                            done,
    output logic [$clog2(WINDOW*drbs_pkg::LIMIT_MM+1)-1:0]  sum_a,
    output logic [$clog2(WINDOW*drbs_pkg::LIMIT_MM+1)-1:0]  sum_b,
    output logic [$clog2(WINDOW+1)-1:0]                     count
);
    import drbs_pkg::*;

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = $clog2(WINDOW * LIMIT_MM + 1);

    logic [DATA_W-1:0] mem_a [WINDOW];
    logic [DATA_W-1:0] mem_b [WINDOW];

    logic [DATA_W-1:0] old_a_reg, old_b_reg;
    logic [DATA_W-1:0] new_a_reg, new_b_reg;
    logic [PTR_W-1:0]  pos_reg, pos_next;
    logic              full_reg;
    logic              wrap;
    logic              upd_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  sum_a_reg, sum_b_reg;
    logic [SUM_W-1:0]  sum_a_next, sum_b_next;
    logic [CNT_W-1:0]  count_reg;

    // The oldest entry leaves the running sum only once every slot holds data.
    always_comb begin
        wrap       = pos_reg == PTR_W'(WINDOW - 1);
        pos_next   = wrap ? '0 : pos_reg + 1'b1;
        sum_a_next = sum_a_reg - (full_reg ? SUM_W'(old_a_reg) : '0) + SUM_W'(new_a_reg);
        sum_b_next = sum_b_reg - (full_reg ? SUM_W'(old_b_reg) : '0) + SUM_W'(new_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            old_a_reg <= mem_a[pos_reg];
            old_b_reg <= mem_b[pos_reg];
            new_a_reg <= new_a;
            new_b_reg <= new_b;
        end
        if (upd_reg) begin
            mem_a[pos_reg] <= new_a_reg;
            mem_b[pos_reg] <= new_b_reg;
            count_reg      <= (wrap || full_reg) ? CNT_W'(WINDOW) : CNT_W'(pos_reg) + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_reg   <= 1'b0;
            done_reg  <= 1'b0;
            pos_reg   <= '0;
            full_reg  <= 1'b0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end else begin
            upd_reg  <= push;
            done_reg <= upd_reg;
            if (upd_reg) begin
                pos_reg   <= pos_next;
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
                if (wrap) begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign sum_a = sum_a_reg;
    assign sum_b = sum_b_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== hdl/dual_range_baseline_smoother_top.sv =====
`default_nettype none

// Channel   Direction  Handshake         Payload
// s_        in         s_valid/s_ready   s_range_a, s_ready_a, s_range_b, s_ready_b
// m_        out        m_valid/m_ready   m_rel_a, m_rel_b_neg
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A beat that produces a result passes from acceptance through the window update
// and the bit-serial divider before the next beat can be accepted.
// A calibration beat that reaches the sample count uses the same divider.
// Reset is synchronous and active low; the window memory is not cleared.
// A result waits in the output register while m_ready is low, and no new beat
// is taken until the previous one has finished.

module dual_range_baseline_smoother_top #(
    parameter int WINDOW = 5
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [drbs_pkg::RANGE_W-1:0]            s_range_a,
    input  logic                                    s_ready_a,
    input  logic [drbs_pkg::RANGE_W-1:0]            s_range_b,
    input  logic                                    s_ready_b,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [drbs_pkg::REL_W-1:0]       m_rel_a,
    output logic signed [drbs_pkg::REL_W-1:0]       m_rel_b_neg,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [drbs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [drbs_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import drbs_pkg::*;

    localparam int WIN_CNT_W = $clog2(WINDOW + 1);
    localparam int WIN_SUM_W = $clog2(WINDOW * LIMIT_MM + 1);

    state_t state_reg, state_next;

    logic                   enable_a_reg, enable_b_reg;
    logic [COUNT_W-1:0]     calib_count_reg;
    logic                   calibrated_reg;
    logic [CALIB_SUM_W-1:0] calib_sum_a_reg, calib_sum_b_reg;
    logic [COUNT_W-1:0]     calib_cnt_a_reg, calib_cnt_b_reg;
    logic [DATA_W-1:0]      offset_a_reg, offset_b_reg;
    logic [DATA_W-1:0]      da_reg, db_reg;
    logic                   m_valid_reg;
    logic [REL_W-1:0]       rel_a_reg, rel_b_neg_reg;

    logic              accept;
    logic              va, vb, data_valid, both_off;
    logic [DATA_W-1:0] da, db;
    logic              cal_hit;

    logic                   win_push, win_done;
    logic [WIN_SUM_W-1:0]   win_sum_a, win_sum_b;
    logic [WIN_CNT_W-1:0]   win_count;
    logic                   div_start, div_sel_cal;
    logic                   div_done_a, div_done_b;
    logic [CALIB_SUM_W-1:0] dividend_a, dividend_b;
    logic [COUNT_W-1:0]     divisor_a, divisor_b;
    logic [QUOT_W-1:0]      quot_a, quot_b;
    logic                   out_load, cal_finish;

    always_comb begin
        va = enable_a_reg && s_ready_a && (s_range_a <= RANGE_W'(LIMIT_MM))
             && (s_range_a != RANGE_W'(NO_TARGET));
        vb = enable_b_reg && s_ready_b && (s_range_b <= RANGE_W'(LIMIT_MM))
             && (s_range_b != RANGE_W'(NO_TARGET));
        da = va ? s_range_a[DATA_W-1:0] : '0;
        db = vb ? s_range_b[DATA_W-1:0] : '0;
        data_valid = va || vb;
        both_off   = !enable_a_reg && !enable_b_reg;
        cal_hit    = (calib_cnt_a_reg >= calib_count_reg)
                     || (calib_cnt_b_reg >= calib_count_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !both_off) begin
                    if (calibrated_reg) begin
                        state_next = ST_PUSH;
                    end else if (data_valid) begin
                        state_next = ST_CAL_CHECK;
                    end
                end
            end
            ST_CAL_CHECK: state_next = cal_hit ? ST_CAL_DIV : ST_IDLE;
            ST_CAL_DIV: begin
                if (div_done_a) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH: state_next = ST_WIN;
            ST_WIN: begin
                if (win_done) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                if (div_done_a) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = state_reg == ST_IDLE;
        win_push    = state_reg == ST_PUSH;
        div_sel_cal = state_reg == ST_CAL_CHECK;
        div_start   = (state_reg == ST_CAL_CHECK && cal_hit)
                      || (state_reg == ST_WIN && win_done);
        out_load    = state_reg == ST_OUT && (!m_valid_reg || m_ready);
        cal_finish  = state_reg == ST_CAL_DIV && div_done_a;
    end

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (div_sel_cal) begin
            dividend_a = calib_sum_a_reg;
            dividend_b = calib_sum_b_reg;
            divisor_a  = calib_cnt_a_reg;
            divisor_b  = calib_cnt_b_reg;
        end else begin
            dividend_a = CALIB_SUM_W'(win_sum_a);
            dividend_b = CALIB_SUM_W'(win_sum_b);
            divisor_a  = COUNT_W'(win_count);
            divisor_b  = COUNT_W'(win_count);
        end
    end

    drbs_win #(
        .WINDOW (WINDOW)
    ) u_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (win_push),
        .new_a   (da_reg),
        .new_b   (db_reg),
        .done    (win_done),
        .sum_a   (win_sum_a),
        .sum_b   (win_sum_b),
        .count   (win_count)
    );

    drbs_div u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend_a),
        .divisor  (divisor_a),
        .done     (div_done_a),
        .quotient (quot_a)
    );

    drbs_div u_div_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend_b),
        .divisor  (divisor_b),
        .done     (div_done_b),
        .quotient (quot_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            enable_a_reg    <= 1'b1;
            enable_b_reg    <= 1'b1;
            calib_count_reg <= CALIB_COUNT_RESET;
            calibrated_reg  <= 1'b0;
            calib_sum_a_reg <= '0;
            calib_sum_b_reg <= '0;
            calib_cnt_a_reg <= '0;
            calib_cnt_b_reg <= '0;
            offset_a_reg    <= '0;
            offset_b_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ENABLE_A:    enable_a_reg    <= cfg_data[0];
                    CFG_ENABLE_B:    enable_b_reg    <= cfg_data[0];
                    CFG_CALIB_COUNT: calib_count_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (accept && !both_off && !calibrated_reg && data_valid) begin
                if (da != '0) begin
                    calib_sum_a_reg <= calib_sum_a_reg + CALIB_SUM_W'(da);
                    calib_cnt_a_reg <= calib_cnt_a_reg + 1'b1;
                end
                if (db != '0) begin
                    calib_sum_b_reg <= calib_sum_b_reg + CALIB_SUM_W'(db);
                    calib_cnt_b_reg <= calib_cnt_b_reg + 1'b1;
                end
            end

            // An offset changes only for an enabled channel that saw samples.
            if (cal_finish) begin
                calibrated_reg <= 1'b1;
                if (enable_a_reg && calib_cnt_a_reg != '0) begin
                    offset_a_reg <= quot_a;
                end
                if (enable_b_reg && calib_cnt_b_reg != '0 && div_done_b) begin
                    offset_b_reg <= quot_b;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            da_reg <= da;
            db_reg <= db;
        end
        if (out_load) begin
            rel_a_reg     <= {1'b0, quot_a} - {1'b0, offset_a_reg};
            rel_b_neg_reg <= {1'b0, offset_b_reg} - {1'b0, quot_b};
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rel_a     = rel_a_reg;
    assign m_rel_b_neg = rel_b_neg_reg;

endmodule

`default_nettype wire
